// ===== hw/rtl/irvl_pkg.sv =====
package irvl_pkg;

    localparam int MAX_INTERVALS = 1024;
    localparam int IDX_W = $clog2(MAX_INTERVALS);
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int SUM_W = 43;
    localparam int MARK_W = 32;
    localparam int RANK_W = 31;
    localparam int OP_W = 2;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [MARK_W-1:0] low_mark;
        logic [MARK_W-1:0] high_mark;
        logic [RANK_W-1:0] query_rank;
    } in_item_t;

endpackage

// ===== hw/rtl/irvl_ram.sv =====
module irvl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/interval_rank_to_value_lookup.sv =====
// channel  dir  beat fields (tdata, lowest bit first)
// s_       in   op[1:0] low_mark[33:2] high_mark[65:34] query_rank[96:66], zero pad to 104
// m_       out  mark[31:0] status[33:32], zero pad to 40
//
// clear, append, unused op, query out of range: result registered in the cycle after the beat
// query: range check on the input beat, then one count memory read per halving step (up
//   to 11 for 1024 entries), the last step also reading the low bound and preceding count;
//   the result beat is registered from the finish state; no input beat is taken until idle
// reset clears the entry count and running total; memories are not cleared
// a waiting result beat holds off new input beats; one item is in work at a time
module interval_rank_to_value_lookup (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // op, low_mark, high_mark, query_rank
    input  logic [irvl_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mark, status
    output logic [irvl_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [irvl_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [irvl_pkg::SUM_W-1:0]       total_reg, total_next;
    logic [irvl_pkg::CNT_W-1:0]       lo_reg, lo_next;
    logic [irvl_pkg::CNT_W-1:0]       hi_reg, hi_next;
    logic [irvl_pkg::IDX_W-1:0]       mid_reg, mid_next;
    logic [irvl_pkg::RANK_W-1:0]      rank_reg, rank_next;
    logic                             m_valid_reg, m_valid_next;
    logic [irvl_pkg::MARK_W-1:0]      m_mark_reg, m_mark_next;
    logic [irvl_pkg::STATUS_W-1:0]    m_status_reg, m_status_next;

    irvl_pkg::in_item_t               item;
    logic                             out_free;
    logic                             in_beat;
    logic [irvl_pkg::MARK_W-1:0]      lo_ord, hi_ord;
    logic [irvl_pkg::MARK_W:0]        span;
    logic [irvl_pkg::SUM_W-1:0]       new_total;
    logic [irvl_pkg::SUM_W-1:0]       rank_ext, rank_reg_ext;
    logic                             full, bad, range_err;

    logic                             cnt_we;
    logic [irvl_pkg::IDX_W-1:0]       cnt_raddr, low_raddr;
    logic [irvl_pkg::SUM_W-1:0]       cnt_rdata;
    logic [irvl_pkg::MARK_W-1:0]      low_rdata;

    logic                             ge;
    logic [irvl_pkg::CNT_W-1:0]       lo_n, hi_n, mid_w;
    logic                             done;
    logic [irvl_pkg::MARK_W-1:0]      before_lo;

    assign item = irvl_pkg::in_item_t'({s_tdata[irvl_pkg::OP_W-1:0],
                                        s_tdata[33:2], s_tdata[65:34], s_tdata[96:66]});
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_beat = s_tvalid && s_tready;

    assign lo_ord = {~item.low_mark[irvl_pkg::MARK_W-1], item.low_mark[irvl_pkg::MARK_W-2:0]};
    assign hi_ord = {~item.high_mark[irvl_pkg::MARK_W-1],
                     item.high_mark[irvl_pkg::MARK_W-2:0]};
    assign span = {1'b0, hi_ord} - {1'b0, lo_ord};
    assign new_total = total_reg + irvl_pkg::SUM_W'(span) + irvl_pkg::SUM_W'(1);
    assign full = count_reg == irvl_pkg::CNT_W'(irvl_pkg::MAX_INTERVALS);
    assign bad = hi_ord < lo_ord;
    assign rank_ext = irvl_pkg::SUM_W'(item.query_rank);
    assign rank_reg_ext = irvl_pkg::SUM_W'(rank_reg);
    assign range_err = (item.query_rank == '0) || (rank_ext > total_reg);

    assign cnt_we = in_beat && (item.op == irvl_pkg::OP_APPEND) && !full && !bad;

    // halving step on the count read back for mid
    assign ge = cnt_rdata >= rank_reg_ext;
    assign lo_n = ge ? lo_reg : irvl_pkg::CNT_W'(mid_reg) + irvl_pkg::CNT_W'(1);
    assign hi_n = ge ? irvl_pkg::CNT_W'(mid_reg) : hi_reg;
    assign mid_w = lo_n + ((hi_n - lo_n) >> 1);
    assign done = !(lo_n < hi_n);

    always_comb begin
        cnt_raddr = count_reg[irvl_pkg::CNT_W-1:1];
        low_raddr = lo_n[irvl_pkg::IDX_W-1:0];
        if (state_reg == S_SEARCH) begin
            if (done) begin
                cnt_raddr = lo_n[irvl_pkg::IDX_W-1:0] - irvl_pkg::IDX_W'(1);
            end else begin
                cnt_raddr = mid_w[irvl_pkg::IDX_W-1:0];
            end
        end
    end

    irvl_ram #(
        .WIDTH(irvl_pkg::SUM_W),
        .DEPTH(irvl_pkg::MAX_INTERVALS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (count_reg[irvl_pkg::IDX_W-1:0]),
        .wr_data (new_total),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rdata)
    );

    irvl_ram #(
        .WIDTH(irvl_pkg::MARK_W),
        .DEPTH(irvl_pkg::MAX_INTERVALS)
    ) u_low_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (count_reg[irvl_pkg::IDX_W-1:0]),
        .wr_data (item.low_mark),
        .rd_addr (low_raddr),
        .rd_data (low_rdata)
    );

    assign before_lo = (lo_reg == '0) ? '0 : cnt_rdata[irvl_pkg::MARK_W-1:0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        total_next = total_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        rank_next = rank_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_mark_next = m_mark_reg;
        m_status_next = m_status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    m_valid_next = 1'b1;
                    m_mark_next = '0;
                    m_status_next = irvl_pkg::ST_OK;
                    unique case (item.op)
                        irvl_pkg::OP_CLEAR: begin
                            count_next = '0;
                            total_next = '0;
                        end
                        irvl_pkg::OP_APPEND: begin
                            if (full) begin
                                m_status_next = irvl_pkg::ST_FULL;
                            end else if (bad) begin
                                m_status_next = irvl_pkg::ST_BAD;
                            end else begin
                                count_next = count_reg + irvl_pkg::CNT_W'(1);
                                total_next = new_total;
                            end
                        end
                        irvl_pkg::OP_QUERY: begin
                            if (range_err) begin
                                m_status_next = irvl_pkg::ST_RANGE;
                            end else begin
                                m_valid_next = 1'b0;
                                state_next = S_SEARCH;
                                lo_next = '0;
                                hi_next = count_reg;
                                mid_next = count_reg[irvl_pkg::CNT_W-1:1];
                                rank_next = item.query_rank;
                            end
                        end
                        irvl_pkg::OP_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                lo_next = lo_n;
                hi_next = hi_n;
                mid_next = mid_w[irvl_pkg::IDX_W-1:0];
                if (done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_mark_next = low_rdata + rank_reg_ext[irvl_pkg::MARK_W-1:0]
                                  - before_lo - irvl_pkg::MARK_W'(1);
                    m_status_next = irvl_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            m_valid_reg <= m_valid_next;
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        mid_reg <= mid_next;
        rank_reg <= rank_next;
        m_mark_reg <= m_mark_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {{(irvl_pkg::M_TDATA_W - irvl_pkg::MARK_W - irvl_pkg::STATUS_W){1'b0}},
                      m_status_reg, m_mark_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= irvl_pkg::CNT_W'(irvl_pkg::MAX_INTERVALS))
        else $error("entry count beyond table depth");

    a_search_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SEARCH |-> (irvl_pkg::CNT_W'(mid_reg) < count_reg) && (lo_reg < hi_reg))
        else $error("search probe outside stored entries");

    a_found_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FINISH |-> lo_reg < count_reg)
        else $error("selected entry outside stored entries");

    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> total_reg == '0)
        else $error("running total nonzero with empty table");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_tready)
        else $error("input taken during a query");

endmodule

// ===== sim/interval_rank_to_value_lookup_tb.sv =====
`timescale 1ns / 100ps

module interval_rank_to_value_lookup_tb;

    localparam int DIR_N = 25;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam longint MARK_MAX = 64'sd2147483647;
    localparam longint MARK_MIN = -64'sd2147483648;
    localparam longint RANK_MAX = 64'd2147483647;

    typedef struct packed {
        logic [irvl_pkg::MARK_W-1:0]   mark;
        logic [irvl_pkg::STATUS_W-1:0] status;
    } lookup_t;

    typedef struct packed {
        irvl_pkg::in_item_t            item;
        logic                          typed;
        logic [irvl_pkg::MARK_W-1:0]   mark;
        logic [irvl_pkg::STATUS_W-1:0] status;
    } dir_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [irvl_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [irvl_pkg::M_TDATA_W-1:0] m_tdata;

    // predictor state
    logic [irvl_pkg::SUM_W-1:0]  tbl_sums [irvl_pkg::MAX_INTERVALS];
    logic [irvl_pkg::MARK_W-1:0] tbl_lows [irvl_pkg::MAX_INTERVALS];
    int                          tbl_used;

    lookup_t  expected_lookups [$];
    dir_row_t directed [DIR_N];
    int       errors;
    int       cycles;
    int       send_idle;
    int       recv_idle;

    interval_rank_to_value_lookup dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic irvl_pkg::in_item_t mk_item(input logic [irvl_pkg::OP_W-1:0] op,
                                                   input logic [31:0] lo,
                                                   input logic [31:0] hi,
                                                   input logic [30:0] rank);
        irvl_pkg::in_item_t it;
        it.op = op;
        it.low_mark = lo;
        it.high_mark = hi;
        it.query_rank = rank;
        return it;
    endfunction

    function automatic dir_row_t drow(input logic [irvl_pkg::OP_W-1:0] op,
                                      input logic [31:0] lo,
                                      input logic [31:0] hi, input logic [30:0] rank,
                                      input logic typed, input logic [31:0] mark,
                                      input logic [irvl_pkg::STATUS_W-1:0] status);
        dir_row_t r;
        r.item = mk_item(op, lo, hi, rank);
        r.typed = typed;
        r.mark = mark;
        r.status = status;
        return r;
    endfunction

    function automatic logic [irvl_pkg::SUM_W-1:0] table_total();
        return (tbl_used == 0) ? '0 : tbl_sums[tbl_used-1];
    endfunction

    // updates the table and gives the value at the queried rank
    function automatic lookup_t predict_lookup(input irvl_pkg::in_item_t it);
        lookup_t                    res;
        logic [31:0]                lo_ord;
        logic [31:0]                hi_ord;
        logic [irvl_pkg::SUM_W-1:0] rank;
        logic [irvl_pkg::SUM_W-1:0] prior_sum;
        logic [irvl_pkg::SUM_W-1:0] offset;
        int                         lo_i;
        int                         hi_i;
        int                         mid;
        res.mark = '0;
        res.status = irvl_pkg::ST_OK;
        case (it.op)
            irvl_pkg::OP_CLEAR: begin
                tbl_used = 0;
            end
            irvl_pkg::OP_APPEND: begin
                lo_ord = it.low_mark ^ 32'h8000_0000;
                hi_ord = it.high_mark ^ 32'h8000_0000;
                if (tbl_used >= irvl_pkg::MAX_INTERVALS) begin
                    res.status = irvl_pkg::ST_FULL;
                end else if (hi_ord < lo_ord) begin
                    res.status = irvl_pkg::ST_BAD;
                end else begin
                    tbl_sums[tbl_used] = table_total() + {11'd0, hi_ord - lo_ord}
                                         + irvl_pkg::SUM_W'(1);
                    tbl_lows[tbl_used] = it.low_mark;
                    tbl_used++;
                end
            end
            irvl_pkg::OP_QUERY: begin
                rank = {12'd0, it.query_rank};
                if (rank == '0 || rank > table_total()) begin
                    res.status = irvl_pkg::ST_RANGE;
                end else begin
                    lo_i = 0;
                    hi_i = tbl_used;
                    while (lo_i < hi_i) begin
                        mid = lo_i + (hi_i - lo_i) / 2;
                        if (tbl_sums[mid] >= rank) begin
                            hi_i = mid;
                        end else begin
                            lo_i = mid + 1;
                        end
                    end
                    prior_sum = (lo_i == 0) ? '0 : tbl_sums[lo_i-1];
                    offset = rank - prior_sum - irvl_pkg::SUM_W'(1);
                    res.mark = tbl_lows[lo_i] + offset[31:0];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic send_item(input irvl_pkg::in_item_t it, input logic typed,
                             input logic [31:0] t_mark,
                             input logic [irvl_pkg::STATUS_W-1:0] t_status);
        lookup_t want;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, it.query_rank, it.high_mark, it.low_mark, it.op};
        do @(posedge aclk); while (!s_tready);
        want = predict_lookup(it);
        if (typed) begin
            want.mark = t_mark;
            want.status = t_status;
        end
        expected_lookups.push_back(want);
    endtask

    task automatic send(input irvl_pkg::in_item_t it);
        send_item(it, 1'b0, '0, irvl_pkg::ST_OK);
    endtask

    // mostly in range, some zero, just past the end or arbitrary
    function automatic logic [30:0] pick_rank();
        longint unsigned total;
        longint unsigned cap;
        int              r;
        total = 64'(table_total());
        r = $urandom_range(9);
        if (total == 0 || r == 0) begin
            return ($urandom_range(1) == 0) ? 31'd0 : 31'($urandom);
        end
        if (r == 1) begin
            return (total < RANK_MAX) ? 31'(total + 1) : 31'($urandom);
        end
        cap = (total < RANK_MAX) ? total : RANK_MAX;
        return 31'(({$urandom, $urandom} % cap) + 1);
    endfunction

    task automatic append_sorted(inout longint cursor, input int max_gap, input int max_size,
                                 input bit allow_huge);
        longint lo;
        longint hi;
        longint size;
        if (cursor > MARK_MAX - 2000) begin
            cursor = MARK_MIN + $urandom_range(0, 1000);
        end
        size = (allow_huge && $urandom_range(15) == 0) ? longint'($urandom) + 1
                                                        : $urandom_range(1, max_size);
        lo = cursor + $urandom_range(0, max_gap);
        hi = lo + size - 1;
        if (hi > MARK_MAX) begin
            hi = MARK_MAX;
        end
        cursor = hi + 1;
        send(mk_item(irvl_pkg::OP_APPEND, lo[31:0], hi[31:0], 31'($urandom)));
    endtask

    task automatic run_random(input int n_items);
        int     sent;
        int     n_app;
        int     n_q;
        longint cursor;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0 || tbl_used > 900) begin
                send(mk_item(irvl_pkg::OP_CLEAR, $urandom, $urandom, 31'($urandom)));
                sent++;
            end
            cursor = longint'($signed($urandom)) / 2;
            n_app = $urandom_range(1, 12);
            repeat (n_app) begin
                if ($urandom_range(9) == 0) begin
                    send(mk_item(irvl_pkg::OP_APPEND, $urandom, $urandom, 31'($urandom)));
                end else begin
                    append_sorted(cursor, 50, 1000, 1'b1);
                end
                sent++;
            end
            n_q = $urandom_range(1, 10);
            repeat (n_q) begin
                send(mk_item(irvl_pkg::OP_QUERY, $urandom, $urandom, pick_rank()));
                sent++;
            end
            if ($urandom_range(7) == 0) begin
                send(mk_item(irvl_pkg::OP_NONE, $urandom, $urandom, 31'($urandom)));
                sent++;
            end
        end
    endtask

    // fills the table to capacity, then appends are refused
    task automatic run_fill();
        longint cursor;
        send(mk_item(irvl_pkg::OP_CLEAR, '0, '0, '0));
        cursor = MARK_MIN + $urandom_range(0, 1000);
        repeat (irvl_pkg::MAX_INTERVALS) begin
            append_sorted(cursor, 3, 4, 1'b0);
        end
        repeat (16) begin
            send(mk_item(irvl_pkg::OP_QUERY, '0, '0, pick_rank()));
        end
        send(mk_item(irvl_pkg::OP_QUERY, '0, '0, 31'(table_total())));
        send_item(mk_item(irvl_pkg::OP_APPEND, 32'd0, 32'd10, '0), 1'b1, '0,
                  irvl_pkg::ST_FULL);
        send_item(mk_item(irvl_pkg::OP_APPEND, 32'd5, 32'd4, '0), 1'b1, '0,
                  irvl_pkg::ST_FULL);
        send_item(mk_item(irvl_pkg::OP_APPEND, $urandom, $urandom, '0), 1'b1, '0,
                  irvl_pkg::ST_FULL);
        repeat (8) begin
            send(mk_item(irvl_pkg::OP_QUERY, '0, '0, pick_rank()));
        end
        send(mk_item(irvl_pkg::OP_CLEAR, '0, '0, '0));
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        lookup_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lookups.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected, tdata %h",
                                          m_tdata));
            end else begin
                want = expected_lookups.pop_front();
                if (m_tdata[31:0] !== want.mark) begin
                    report_mismatch($sformatf("mark %h, expected %h", m_tdata[31:0],
                                              want.mark));
                end
                if (m_tdata[33:32] !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d", m_tdata[33:32],
                                              want.status));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("interval_rank_to_value_lookup verification failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        errors = 0;
        cycles = 0;
        tbl_used = 0;
        send_idle = 10;
        recv_idle = 86;

        directed = '{
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd1,
                 1'b1, 32'd0, irvl_pkg::ST_RANGE),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_RANGE),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'h7FFF_FFFF,
                 1'b1, 32'd0, irvl_pkg::ST_RANGE),
            drow(irvl_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                 1'b1, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_APPEND, 32'd5, 32'd4, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_BAD),
            drow(irvl_pkg::OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd1,
                 1'b1, 32'h8000_0000, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'h7FFF_FFFF,
                 1'b1, 32'hFFFF_FFFE, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_BAD),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_RANGE),
            drow(irvl_pkg::OP_CLEAR, 32'd0, 32'd0, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd1,
                 1'b1, 32'd0, irvl_pkg::ST_RANGE),
            drow(irvl_pkg::OP_APPEND, -32'sd10, -32'sd1, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_APPEND, 32'd0, 32'd0, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_APPEND, 32'd100, 32'd199, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd10,
                 1'b0, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd11,
                 1'b0, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd12,
                 1'b0, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd111,
                 1'b0, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd112,
                 1'b1, 32'd0, irvl_pkg::ST_RANGE),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd1,
                 1'b0, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_NONE, 32'd0, 32'd0, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_QUERY, 32'd0, 32'd0, 31'd5,
                 1'b0, 32'd0, irvl_pkg::ST_OK),
            drow(irvl_pkg::OP_CLEAR, 32'd0, 32'd0, 31'd0,
                 1'b1, 32'd0, irvl_pkg::ST_OK)
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_item(directed[i].item, directed[i].typed, directed[i].mark,
                      directed[i].status);
        end
        run_random(320);

        send_idle = 86;
        recv_idle = 10;
        run_random(320);

        send_idle = 0;
        recv_idle = 0;
        run_fill();
        run_random(320);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("interval_rank_to_value_lookup verification clean");
        end else begin
            $display("interval_rank_to_value_lookup verification failed");
        end
        $finish;
    end

endmodule
